/* rtl/insertion_sorter_macros.svh */
// Assertion macros shared by the insertion sorter checker.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ISORT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property, checked in every cycle including reset.
`define ISORT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/isort_pkg.sv */
// Types and constants for the insertion sorter.
package isort_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic  insert;
        logic  pop;
        data_t value;
    } cell_ctrl_t;

endpackage

/* rtl/insertion_sorter.sv */
// Insertion sorter: a chain of CAPACITY cells keeps the collected set in
// ascending order; every cell compares its entry with the incoming value in
// the same cycle, so one beat is accepted per cycle while a set is collected.
// The beat with s_last_in closes the set; the chain then shifts toward its
// head and shows one result per cycle while m_ready is high, holding input
// off. Equal values keep their arrival order. Values arriving at a full chain
// are dropped and m_overflow is high on every result of that run.
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic signed [31:0] s_value_in,
    input  logic              s_last_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [31:0] m_value_out,
    output logic              m_last_out,
    output logic              m_overflow
);

    state_t     state_reg, state_next;
    logic       drop_reg, drop_next;
    logic       ovf_reg, ovf_next;
    logic       s_beat, m_beat, full;
    cell_ctrl_t ctrl;

    logic  cell_valid [CAPACITY];
    logic  cell_gt    [CAPACITY];
    data_t cell_value [CAPACITY];

    assign full   = cell_valid[CAPACITY-1];
    assign s_beat = s_valid && s_ready;
    assign m_beat = m_valid && m_ready;

    assign ctrl.insert = s_beat && !full;
    assign ctrl.pop    = m_beat;
    assign ctrl.value  = s_value_in;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic  pv, pg, nv;
        data_t pval, nval;
        if (i == 0) begin : g_head
            assign pv   = 1'b1;
            assign pg   = 1'b0;
            assign pval = '0;
        end else begin : g_body
            assign pv   = cell_valid[i-1];
            assign pg   = cell_gt[i-1];
            assign pval = cell_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign nv   = 1'b0;
            assign nval = '0;
        end else begin : g_mid
            assign nv   = cell_valid[i+1];
            assign nval = cell_value[i+1];
        end
        isort_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_valid (pv),
            .prev_gt    (pg),
            .prev_value (pval),
            .next_valid (nv),
            .next_value (nval),
            .valid      (cell_valid[i]),
            .gt         (cell_gt[i]),
            .value      (cell_value[i])
        );
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_COLLECT: begin
                if (s_beat && s_last_in) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (m_beat && m_last_out) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_COLLECT: s_ready = 1'b1;
            ST_DRAIN:   m_valid = cell_valid[0];
            default:    s_ready = 1'b0;
        endcase
    end

    assign m_value_out = cell_value[0];
    assign m_last_out  = !cell_valid[1];
    assign m_overflow  = ovf_reg;

    always_comb begin
        drop_next = drop_reg;
        ovf_next  = ovf_reg;
        if (s_beat) begin
            if (s_last_in) begin
                ovf_next  = drop_reg || full;
                drop_next = 1'b0;
            end else if (full) begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            drop_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            drop_reg  <= drop_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

/* rtl/isort_cell.sv */
// One cell of the sorting chain: holds a value and its valid bit.
module isort_cell
    import isort_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic       prev_valid,
    input  logic       prev_gt,
    input  data_t      prev_value,
    input  logic       next_valid,
    input  data_t      next_value,
    output logic       valid,
    output logic       gt,
    output data_t      value
);

    logic  valid_reg, valid_next;
    data_t value_reg, value_next;

    // Stored value sorts after the incoming one: it moves one place up.
    assign gt    = valid_reg && (value_reg > ctrl.value);
    assign valid = valid_reg;
    assign value = value_reg;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.insert) begin
            if (prev_gt) begin
                value_next = prev_value;
                valid_next = 1'b1;
            end else if (gt || (!valid_reg && prev_valid)) begin
                value_next = ctrl.value;
                valid_next = 1'b1;
            end
        end else if (ctrl.pop) begin
            // advance toward the head
            value_next = next_value;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

endmodule

/* rtl/isort_checker.sv */
// Port-level checker for the insertion sorter, bound to the top level.
`include "insertion_sorter_macros.svh"

module isort_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic signed [31:0] s_value_in,
    input logic              s_last_in,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [31:0] m_value_out,
    input logic              m_last_out,
    input logic              m_overflow
);

    `ISORT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_value_out), "result beat dropped or changed while stalled")
    `ISORT_ASSERT_ALWAYS(a_no_overlap, aclk, !(s_ready && m_valid), "input taken while results pending")
    `ISORT_ASSERT(a_run_starts, aclk, aresetn, s_valid && s_ready && s_last_in |=> m_valid, "closing beat did not start a run")
    `ISORT_ASSERT(a_run_ends, aclk, aresetn, m_valid && m_ready && m_last_out |=> !m_valid && s_ready, "run did not end after final beat")
    `ISORT_ASSERT(a_ovf_steady, aclk, aresetn, m_valid && m_ready && !m_last_out |=> m_valid && m_overflow == $past(m_overflow), "overflow changed within a run")

endmodule

bind insertion_sorter isort_checker u_isort_checker (.*);

/* tb/insertion_sorter_checker.sv */
// Scoreboard for the insertion sorter: predicts every sorted run and checks the result beats.
module insertion_sorter_checker
    import isort_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_ready,
    input  data_t s_value_in,
    input  logic  s_last_in,
    input  logic  m_valid,
    input  logic  m_ready,
    input  data_t m_value_out,
    input  logic  m_last_out,
    input  logic  m_overflow,
    output int    fail_count,
    output int    pending,
    output int    runs_closed,
    output int    runs_overflowed,
    output int    results_checked
);

    typedef struct packed {
        data_t value;
        logic  last;
        logic  overflow;
    } sorted_beat_t;

    data_t        sorted_vals [CAPACITY];
    int           fill_count;
    logic         dropped;
    sorted_beat_t sorted_q [$];

    initial begin
        fail_count      = 0;
        pending         = 0;
        runs_closed     = 0;
        runs_overflowed = 0;
        results_checked = 0;
        fill_count      = 0;
        dropped         = 1'b0;
    end

    // Insert after every stored value <= v, so equal values keep arrival order.
    function automatic void insert_value(data_t v);
        int pos;
        if (fill_count >= CAPACITY) begin
            dropped = 1'b1;
            return;
        end
        pos = fill_count;
        while (pos > 0 && sorted_vals[pos-1] > v) begin
            sorted_vals[pos] = sorted_vals[pos-1];
            pos--;
        end
        sorted_vals[pos] = v;
        fill_count++;
    endfunction

    // Queue the whole run in ascending order, then empty the store.
    function automatic void close_run();
        sorted_beat_t b;
        for (int k = 0; k < fill_count; k++) begin
            b.value    = sorted_vals[k];
            b.last     = (k == fill_count - 1);
            b.overflow = dropped;
            sorted_q.push_back(b);
        end
        runs_closed++;
        if (dropped)
            runs_overflowed++;
        fill_count = 0;
        dropped    = 1'b0;
    endfunction

    always @(posedge aclk) begin
        sorted_beat_t exp_beat;
        if (!aresetn) begin
            fill_count = 0;
            dropped    = 1'b0;
            sorted_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                insert_value(s_value_in);
                if (s_last_in)
                    close_run();
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (sorted_q.size() == 0) begin
                    $error("unexpected result beat: value_out=%0d last_out=%0b overflow=%0b",
                           m_value_out, m_last_out, m_overflow);
                    fail_count++;
                end else begin
                    exp_beat = sorted_q.pop_front();
                    if (m_value_out !== exp_beat.value) begin
                        $error("value_out: expected %0d, got %0d", exp_beat.value, m_value_out);
                        fail_count++;
                    end
                    if (m_last_out !== exp_beat.last) begin
                        $error("last_out: expected %0b, got %0b", exp_beat.last, m_last_out);
                        fail_count++;
                    end
                    if (m_overflow !== exp_beat.overflow) begin
                        $error("overflow: expected %0b, got %0b", exp_beat.overflow, m_overflow);
                        fail_count++;
                    end
                end
            end
        end
        pending = sorted_q.size();
    end

endmodule

/* tb/tb_insertion_sorter.sv */
// Testbench top for the insertion sorter: drives sets of values, applies backpressure, gives the verdict.
module tb_insertion_sorter;
    import isort_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = CAPACITY + 20;
    localparam int LONG_HOLD   = 300;

    logic  aclk       = 1'b0;
    logic  aresetn    = 1'b0;
    logic  s_valid    = 1'b0;
    logic  s_ready;
    data_t s_value_in = '0;
    logic  s_last_in  = 1'b0;
    logic  m_valid;
    logic  m_ready    = 1'b0;
    data_t m_value_out;
    logic  m_last_out;
    logic  m_overflow;

    int fail_count;
    int pending;
    int runs_closed;
    int runs_overflowed;
    int results_checked;

    int          beats_sent    = 0;
    int          send_idle_pct = 14;
    int          recv_idle_pct = 47;
    bit          hold_req      = 1'b0;
    int unsigned cycle_count   = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    insertion_sorter #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value_in  (s_value_in),
        .s_last_in   (s_last_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value_out (m_value_out),
        .m_last_out  (m_last_out),
        .m_overflow  (m_overflow)
    );

    insertion_sorter_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value_in      (s_value_in),
        .s_last_in       (s_last_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value_out     (m_value_out),
        .m_last_out      (m_last_out),
        .m_overflow      (m_overflow),
        .fail_count      (fail_count),
        .pending         (pending),
        .runs_closed     (runs_closed),
        .runs_overflowed (runs_overflowed),
        .results_checked (results_checked)
    );

    // Mostly full-range values, some tightly clustered ones to force ties, and the extremes.
    function automatic data_t rand_value();
        case ($urandom_range(9))
            5, 6, 7: return data_t'($urandom_range(8)) - 4;
            8:       return 32'sh7fff_ffff;
            9:       return 32'sh8000_0000;
            default: return data_t'($urandom);
        endcase
    endfunction

    function automatic int rand_set_len();
        if ($urandom_range(7) == 0)
            return $urandom_range(CAPACITY + 6, CAPACITY - 4);
        return $urandom_range(12, 1);
    endfunction

    // Offer one beat and hold it until accepted; idle first at the sender's rate.
    task automatic send_beat(input data_t v, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid    <= 1'b1;
        s_value_in <= v;
        s_last_in  <= last;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic send_list(input data_t vals[$]);
        for (int i = 0; i < vals.size(); i++)
            send_beat(vals[i], i == vals.size() - 1);
    endtask

    task automatic send_rand_set(input int n);
        for (int i = 0; i < n; i++)
            send_beat(rand_value(), i == n - 1);
    endtask

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, pending);
        $display("status: fail");
        $finish;
    end

    initial begin
        data_t dir_q [$];
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-element run
        dir_q = '{32'sd0};
        send_list(dir_q);
        // extremes and repeated values mixed
        dir_q = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1,
                  32'sh8000_0000, 32'sh7fff_ffff, -32'sd1};
        send_list(dir_q);
        // all equal
        dir_q = '{32'sd5, 32'sd5, 32'sd5};
        send_list(dir_q);
        // descending: every value lands at the head
        dir_q = '{32'sd4, 32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1};
        send_list(dir_q);
        // closing value larger than the rest
        dir_q = '{-32'sd3, 32'sd9};
        send_list(dir_q);

        // let the last short run drain so the hold-off lands on a filling chain
        while (pending != 0)
            @(posedge aclk);

        // exactly full store, drained under a long receiver hold-off
        hold_req = 1'b1;
        send_rand_set(CAPACITY);
        while (beats_sent < 90)
            send_rand_set(rand_set_len());

        send_idle_pct = 47;
        recv_idle_pct = 14;
        send_rand_set(CAPACITY + 2);
        while (beats_sent < 170)
            send_rand_set(rand_set_len());

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // closing value itself dropped from a full store
        send_rand_set(CAPACITY + 1);
        while (beats_sent < 250)
            send_rand_set(rand_set_len());

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d values in %0d sets (%0d overflowed); checked %0d sorted results",
                 beats_sent, runs_closed, runs_overflowed, results_checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
